### rtl/core/histogram_auto_contrast_window_unit_assert.svh
// Assertion macros for the histogram auto-contrast window top level.
`ifndef HISTOGRAM_AUTO_CONTRAST_WINDOW_UNIT_ASSERT_SVH
`define HISTOGRAM_AUTO_CONTRAST_WINDOW_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HACW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HACW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HACW_ASSERT_NOW(lbl, ante, cons, msg)
`define HACW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/hacw_pkg.sv
// Types and constants of the histogram auto-contrast window unit.
package hacw_pkg;

    localparam int ACC_W = 48;
    localparam int MUL_W = ACC_W + 10;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_GT     = 2'd1;
    localparam logic [1:0] OP_CHK_LO = 2'd2;
    localparam logic [1:0] OP_CHK_HI = 2'd3;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } t_in;

    typedef struct packed {
        logic       valid_res;
        logic [7:0] pix_min;
        logic [7:0] pix_max;
        logic [7:0] win_low;
        logic [8:0] win_high;
        logic [7:0] nz_low;
        logic [7:0] nz_high;
    } t_out;

    typedef struct packed {
        logic [1:0]       op;
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
    } t_alu_req;

endpackage

### rtl/core/hacw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hacw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/hacw_alu.sv
// Shared add and threshold-compare unit used by the frame close sequencer.
module hacw_alu (
    input  hacw_pkg::t_alu_req           i_req,
    output logic [hacw_pkg::ACC_W-1:0]   o_sum,
    output logic                         o_flag
);
    import hacw_pkg::*;

    logic [MUL_W-1:0] w_a;
    logic [MUL_W-1:0] w_b;

    assign w_a   = MUL_W'(i_req.a);
    assign w_b   = MUL_W'(i_req.b);
    assign o_sum = i_req.a + i_req.b;

    always_comb begin
        case (i_req.op)
            OP_GT:     o_flag = i_req.b > i_req.a;
            // 90 percent of the left mass
            OP_CHK_LO: o_flag = (w_a * MUL_W'(10)) >= (w_b * MUL_W'(9));
            // 99.6 percent of the right mass
            OP_CHK_HI: o_flag = (w_a * MUL_W'(1000)) >= (w_b * MUL_W'(996));
            default:   o_flag = 1'b0;
        endcase
    end
endmodule

### rtl/core/histogram_auto_contrast_window_unit.sv
// Top level of the histogram auto-contrast window unit.
//
// Usage: pixels of a frame enter on the input channel (i_in_valid, o_in_stall,
// i_in) in raster order; the pixel with last set closes the frame. One result
// transaction per frame leaves on the output channel (o_out_valid,
// i_out_stall, o_out).
// Pixels: each pixel passes accept, histogram read and write back before the
// next is taken; the histogram RAM's single read port is the reason.
// Result after the last pixel: flat frames go straight to the histogram
// flush. Other frames run a sequencer over the shared ALU: peak scan, two
// mass sums, two walks over at most BINS bins together, one window check,
// then the flush.
// Reset: a clearing pass over every bin zeroes the histogram; o_in_stall
// stays high until it ends.
// Stall: the result sits in an output register; the sequencer finishes the
// next frame through the flush and then holds until that register is taken.
`include "histogram_auto_contrast_window_unit_assert.svh"
module histogram_auto_contrast_window_unit #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  hacw_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output hacw_pkg::t_out o_out
);
    import hacw_pkg::*;

    localparam int IW = $clog2(BINS);
    localparam int CW = IW + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [CW-1:0] LAST_IDX = CW'(BINS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PX_RD = 4'd1;
    localparam logic [3:0] S_PX_WR = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_SUMLO = 4'd4;
    localparam logic [3:0] S_SUMHI = 4'd5;
    localparam logic [3:0] S_LOW   = 4'd6;
    localparam logic [3:0] S_HIGH  = 4'd7;
    localparam logic [3:0] S_COLL  = 4'd8;
    localparam logic [3:0] S_FLUSH = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]            r_st;
    logic [1:0]            r_ph;
    logic [CW-1:0]         r_idx;
    logic [IW-1:0]         r_pix_idx;
    logic                  r_last;
    logic [7:0]            r_min;
    logic [7:0]            r_max;
    logic [COUNT_BITS-1:0] r_best;
    logic [IW-1:0]         r_peak;
    logic [IW-1:0]         r_nzl;
    logic [IW-1:0]         r_nzh;
    logic                  r_hit;
    logic [ACC_W-1:0]      r_slo;
    logic [ACC_W-1:0]      r_shi;
    logic [ACC_W-1:0]      r_cur;
    logic [IW-1:0]         r_lo;
    logic [CW-1:0]         r_hi;
    logic                  r_boot;
    logic                  r_ov;
    t_out                  r_out;

    logic                  w_accept;
    logic [IW-1:0]         w_in_idx;
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;
    logic [IW-1:0]         w_raddr;
    logic [COUNT_BITS-1:0] w_rdata;
    t_alu_req              w_req;
    logic [ACC_W-1:0]      w_sum;
    logic                  w_flag;
    logic                  w_load;
    logic                  w_at_last;
    logic                  w_win_zero;

    assign o_in_stall  = (r_st != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign w_at_last   = (r_idx == LAST_IDX);
    assign w_load      = (r_st == S_OUT) && (!r_ov || !i_out_stall);
    assign w_win_zero  = (o_out.win_low == 8'd0) && (o_out.win_high == 9'd0)
                      && (o_out.nz_low == 8'd0) && (o_out.nz_high == 8'd0);

    // Pixels beyond the bin range land in the top bin.
    assign w_in_idx = (32'(i_in.pixel) >= BINS) ? IW'(BINS - 1) : IW'(i_in.pixel);

    // Histogram port control: read-modify-write per pixel, zero on flush.
    always_comb begin
        w_raddr = (r_st == S_PX_RD) ? r_pix_idx : r_idx[IW-1:0];
        w_we    = 1'b0;
        w_waddr = r_idx[IW-1:0];
        w_wdata = '0;
        case (r_st)
            S_PX_WR: begin
                w_we    = 1'b1;
                w_waddr = r_pix_idx;
                w_wdata = (w_rdata == CNT_MAX) ? w_rdata : w_rdata + 1'b1;
            end
            S_FLUSH: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    hacw_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BINS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Route operands to the shared unit by sequencer step.
    always_comb begin
        w_req.op = OP_ADD;
        w_req.a  = r_cur;
        w_req.b  = ACC_W'(w_rdata);
        case (r_st)
            S_SCAN: begin
                w_req.op = OP_GT;
                w_req.a  = ACC_W'(r_best);
            end
            S_SUMLO: w_req.a = r_slo;
            S_SUMHI: w_req.a = r_shi;
            S_LOW: begin
                if (r_ph == 2'd2) begin
                    w_req.op = OP_CHK_LO;
                    w_req.b  = r_slo;
                end
            end
            S_HIGH: begin
                if (r_ph == 2'd2) begin
                    w_req.op = OP_CHK_HI;
                    w_req.b  = r_shi;
                end
            end
            default: w_req.op = OP_ADD;
        endcase
    end

    hacw_alu u_alu (
        .i_req  (w_req),
        .o_sum  (w_sum),
        .o_flag (w_flag)
    );

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_pix_idx <= w_in_idx;
                r_last    <= i_in.last;
            end
            S_PX_WR: begin
                // Zero the window fields up front; a flat frame keeps them.
                r_best <= '0;
                r_peak <= '0;
                r_nzl  <= '0;
                r_nzh  <= '0;
                r_lo   <= '0;
                r_hi   <= '0;
                r_slo  <= '0;
                r_shi  <= '0;
                r_cur  <= '0;
            end
            S_SCAN: begin
                if (r_ph == 2'd1) begin
                    if (w_flag) begin
                        r_best <= w_rdata;
                        r_peak <= r_idx[IW-1:0];
                    end
                    if (w_rdata != '0) begin
                        if (!r_hit) begin
                            r_nzl <= r_idx[IW-1:0];
                        end
                        r_nzh <= r_idx[IW-1:0];
                    end
                end
            end
            S_SUMLO: begin
                if (r_ph == 2'd1) begin
                    r_slo <= w_sum;
                end
            end
            S_SUMHI: begin
                if (r_ph == 2'd1) begin
                    r_shi <= w_sum;
                end
            end
            S_LOW: begin
                if (r_ph == 2'd1) begin
                    r_cur <= w_sum;
                end else if (r_ph == 2'd2) begin
                    if (w_flag) begin
                        r_lo  <= r_idx[IW-1:0];
                        r_cur <= '0;
                    end else if (r_idx == CW'(1)) begin
                        r_cur <= '0;
                    end
                end
            end
            S_HIGH: begin
                if (r_ph == 2'd1) begin
                    r_cur <= w_sum;
                end else if (r_ph == 2'd2) begin
                    if (w_flag) begin
                        r_hi <= r_idx + 1'b1;
                    end else if (w_at_last) begin
                        r_hi <= CW'(BINS);
                    end
                end
            end
            S_COLL: begin
                if (CW'(r_lo) >= r_hi) begin
                    r_lo <= '0;
                    r_hi <= LAST_IDX;
                end
            end
            default: begin
                r_lo <= r_lo;
            end
        endcase
        if (w_load) begin
            r_out.valid_res <= (r_min != r_max);
            r_out.pix_min   <= r_min;
            r_out.pix_max   <= r_max;
            r_out.win_low   <= 8'(r_lo);
            r_out.win_high  <= 9'(r_hi);
            r_out.nz_low    <= 8'(r_nzl);
            r_out.nz_high   <= 8'(r_nzh);
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_FLUSH;
            r_ph   <= '0;
            r_idx  <= '0;
            r_boot <= 1'b1;
            r_ov   <= 1'b0;
            r_min  <= 8'hFF;
            r_max  <= 8'h00;
            r_hit  <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in.pixel < r_min) begin
                            r_min <= i_in.pixel;
                        end
                        if (i_in.pixel > r_max) begin
                            r_max <= i_in.pixel;
                        end
                        r_st <= S_PX_RD;
                    end
                end
                S_PX_RD: r_st <= S_PX_WR;
                S_PX_WR: begin
                    r_idx <= '0;
                    r_ph  <= '0;
                    r_hit <= 1'b0;
                    if (!r_last) begin
                        r_st <= S_IDLE;
                    end else if (r_min != r_max) begin
                        r_st <= S_SCAN;
                    end else begin
                        r_st <= S_FLUSH;
                    end
                end
                S_SCAN: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if (w_rdata != '0) begin
                            r_hit <= 1'b1;
                        end
                        if (w_at_last) begin
                            r_idx <= '0;
                            r_st  <= S_SUMLO;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_SUMLO: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if (r_idx[IW-1:0] == r_peak) begin
                            r_st <= S_SUMHI;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_SUMHI: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if (w_at_last) begin
                            r_idx <= CW'(r_peak);
                            // Peak at bin zero leaves no low walk.
                            r_st  <= (r_peak == '0) ? S_HIGH : S_LOW;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_LOW: begin
                    case (r_ph)
                        2'd0: r_ph <= 2'd1;
                        2'd1: r_ph <= 2'd2;
                        default: begin
                            r_ph <= 2'd0;
                            if (w_flag || r_idx == CW'(1)) begin
                                r_idx <= CW'(r_peak);
                                r_st  <= S_HIGH;
                            end else begin
                                r_idx <= r_idx - 1'b1;
                            end
                        end
                    endcase
                end
                S_HIGH: begin
                    case (r_ph)
                        2'd0: r_ph <= 2'd1;
                        2'd1: r_ph <= 2'd2;
                        default: begin
                            r_ph <= 2'd0;
                            if (w_flag || w_at_last) begin
                                r_st <= S_COLL;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    endcase
                end
                S_COLL: begin
                    r_idx <= '0;
                    r_st  <= S_FLUSH;
                end
                S_FLUSH: begin
                    if (w_at_last) begin
                        r_idx  <= '0;
                        r_boot <= 1'b0;
                        r_st   <= r_boot ? S_IDLE : S_OUT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OUT: begin
                    // Hold until the output register is free, then reopen.
                    if (w_load) begin
                        r_ov  <= 1'b1;
                        r_min <= 8'hFF;
                        r_max <= 8'h00;
                        r_st  <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `HACW_ASSERT_NEXT(a_accept_busy, w_accept, o_in_stall, "pixel accept did not start work")
    `HACW_ASSERT_NOW(a_flat_zero, o_out_valid && !o_out.valid_res, w_win_zero, "flat frame has window")
    `HACW_ASSERT_NOW(a_min_below_max, o_out_valid && o_out.valid_res, o_out.pix_min < o_out.pix_max, "min not below max")
endmodule
